FILE: src/ofbc_pkg.sv
// shared types and constants of the fragment buffer compositor
package ofbc_pkg;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_COMPOSE = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int CFG_W = 9;

    typedef enum logic [1:0] {
        ST_COMPOSED     = 2'd0,
        ST_EMPTY        = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [23:0] depth;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } frag_t;

    typedef struct packed {
        logic    in_ready;
        logic    latch;
        logic    cnt_rd;
        logic    add_wr;
        logic    clr_step;
        logic    comp_init;
        logic    frag_rd;
        logic    lane_ins;
        logic    blend_mul;
        logic    blend_div;
        logic    blend_fix;
        logic    out_load;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] op;
        logic       in_range;
        logic       cnt_full;
        logic       cnt_zero;
        logic       clr_last;
        logic       fetch_done;
        logic       blend_last;
        logic       out_busy;
    } sts_t;

endpackage

FILE: src/ofbc_ifs.sv
// item channels of the fragment buffer compositor
interface ofbc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [23:0]        frag_depth;
    logic [7:0]         frag_red;
    logic [7:0]         frag_green;
    logic [7:0]         frag_blue;
    logic [7:0]         frag_alpha;
    logic [7:0]         base_red;
    logic [7:0]         base_green;
    logic [7:0]         base_blue;

    modport source (output valid, op, pos_x, pos_y, frag_depth, frag_red, frag_green,
                    frag_blue, frag_alpha, base_red, base_green, base_blue,
                    input ready);
    modport sink (input valid, op, pos_x, pos_y, frag_depth, frag_red, frag_green,
                  frag_blue, frag_alpha, base_red, base_green, base_blue,
                  output ready);
endinterface

interface ofbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [1:0] status;

    modport source (output valid, out_red, out_green, out_blue, status, input ready);
    modport sink (input valid, out_red, out_green, out_blue, status, output ready);
endinterface

FILE: src/ofbc_ctrl.sv
// sequencing state machine of the fragment buffer compositor
module ofbc_ctrl
    import ofbc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_COUNT,
        S_FETCH,
        S_MUL,
        S_DIV,
        S_FIX,
        S_RESULT
    } state_t;

    state_t  state_reg, state_next;
    status_t res_reg, res_next;
    logic    rd_pend_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.out_status = res_reg;
        state_next = state_reg;
        res_next   = res_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.latch    = sts.in_valid;
                if (sts.in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_CLEAR:
                        state_next = S_CLEAR;
                    OP_ADD:
                    begin
                        cmd.cnt_rd = sts.in_range;
                        state_next = sts.in_range ? S_COUNT : S_IDLE;
                    end
                    OP_COMPOSE:
                    begin
                        cmd.cnt_rd = sts.in_range;
                        if (sts.in_range)
                            state_next = S_COUNT;
                        else
                        begin
                            res_next   = ST_OUT_OF_RANGE;
                            state_next = S_RESULT;
                        end
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_COUNT:
            begin
                if (sts.op == OP_COMPOSE)
                begin
                    if (sts.cnt_zero)
                    begin
                        res_next   = ST_EMPTY;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        cmd.comp_init = 1'b1;
                        state_next    = S_FETCH;
                    end
                end
                else
                begin
                    cmd.add_wr = !sts.cnt_full;
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                cmd.frag_rd  = !sts.fetch_done;
                cmd.lane_ins = rd_pend_reg;
                if (sts.fetch_done && !rd_pend_reg)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.blend_mul = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.blend_div = 1'b1;
                state_next    = S_FIX;
            end
            S_FIX:
            begin
                cmd.blend_fix = 1'b1;
                if (sts.blend_last)
                begin
                    res_next   = ST_COMPOSED;
                    state_next = S_RESULT;
                end
                else
                    state_next = S_MUL;
            end
            S_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            res_reg     <= ST_COMPOSED;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            rd_pend_reg <= cmd.frag_rd;
        end
    end

endmodule

FILE: src/ofbc_dp.sv
// datapath: stores, sorting lanes and blend arithmetic
module ofbc_dp
    import ofbc_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_FRAGS  = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output sts_t             sts,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    ofbc_in_if.sink          in_ch,
    ofbc_out_if.source       out_ch
);

    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int PW     = XW + YW;
    localparam int CW     = $clog2(MAX_FRAGS + 1);
    localparam int SW     = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int PIXELS = 1 << PW;
    localparam int SLOTS  = PIXELS << SW;

    function automatic logic [7:0] to_byte(input logic [15:0] v);
        logic [23:0] y;
        logic [7:0]  q0;
        logic [16:0] r;
        logic [8:0]  b;
        y  = (24'(v) << 8) - 24'(v) + 24'd32767;
        q0 = y[23:16];
        r  = 17'(y[15:0]) + 17'(q0);
        b  = 9'(q0) + ((r >= 17'd65535) ? 9'd1 : 9'd0);
        return (b > 9'd255) ? 8'hFF : b[7:0];
    endfunction

    // configuration
    logic [CFG_W-1:0] width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(256);
            height_reg <= CFG_W'(256);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= cfg_data;
            if (cfg_index == REG_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // item registers
    logic [1:0]         op_reg;
    logic signed [10:0] x_pos_reg, y_pos_reg;
    frag_t              item_reg;
    logic [7:0]         base_reg [3];

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= in_ch.op;
            x_pos_reg   <= in_ch.pos_x;
            y_pos_reg   <= in_ch.pos_y;
            item_reg    <= '{depth: in_ch.frag_depth, red: in_ch.frag_red,
                             green: in_ch.frag_green, blue: in_ch.frag_blue,
                             alpha: in_ch.frag_alpha};
            base_reg[0] <= in_ch.base_red;
            base_reg[1] <= in_ch.base_green;
            base_reg[2] <= in_ch.base_blue;
        end
    end

    assign in_ch.ready = cmd.in_ready;

    logic          in_range;
    logic [PW-1:0] pix;

    assign in_range = !x_pos_reg[10] && !y_pos_reg[10]
                      && ({1'b0, x_pos_reg[9:0]} < {2'b0, width_reg})
                      && ({1'b0, y_pos_reg[9:0]} < {2'b0, height_reg})
                      && (32'(x_pos_reg[9:0]) < MAX_WIDTH)
                      && (32'(y_pos_reg[9:0]) < MAX_HEIGHT);
    assign pix = {YW'(y_pos_reg[9:0]), XW'(x_pos_reg[9:0])};

    // per-pixel count memory with clearing sweep
    logic [CW-1:0] cnt_mem [PIXELS];
    logic [CW-1:0] cnt_q;
    logic [PW-1:0] clr_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            cnt_mem[clr_addr_reg] <= '0;
        else if (cmd.add_wr)
            cnt_mem[pix] <= cnt_q + CW'(1);
        if (cmd.cnt_rd)
            cnt_q <= cnt_mem[pix];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_step)
            clr_addr_reg <= clr_addr_reg + PW'(1);
    end

    // fragment store
    frag_t         store_mem [SLOTS];
    frag_t         store_q;
    logic [CW-1:0] n_reg, fetch_idx_reg, left_reg, lane_n_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.add_wr)
            store_mem[{pix, cnt_q[SW-1:0]}] <= item_reg;
        if (cmd.frag_rd)
            store_q <= store_mem[{pix, fetch_idx_reg[SW-1:0]}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            fetch_idx_reg <= '0;
            left_reg      <= '0;
            lane_n_reg    <= '0;
        end
        else
        begin
            if (cmd.comp_init)
            begin
                n_reg         <= cnt_q;
                fetch_idx_reg <= '0;
                left_reg      <= cnt_q;
                lane_n_reg    <= '0;
            end
            else
            begin
                if (cmd.frag_rd)
                    fetch_idx_reg <= fetch_idx_reg + CW'(1);
                if (cmd.lane_ins)
                    lane_n_reg <= lane_n_reg + CW'(1);
                if (cmd.blend_fix)
                    left_reg <= left_reg - CW'(1);
            end
        end
    end

    // sorted lanes, farthest in lane 0; ties stay behind earlier arrivals
    frag_t                lane_reg [MAX_FRAGS];
    logic [MAX_FRAGS-1:0] ge;

    for (genvar i = 0; i < MAX_FRAGS; i++)
    begin : g_lane
        assign ge[i] = (CW'(i) < lane_n_reg) && (lane_reg[i].depth >= store_q.depth);

        always_ff @(posedge clk)
        begin
            if (cmd.lane_ins && !ge[i])
            begin
                if (i == 0)
                    lane_reg[i] <= store_q;
                else if (ge[(i > 0) ? i - 1 : 0])
                    lane_reg[i] <= store_q;
                else
                    lane_reg[i] <= lane_reg[(i > 0) ? i - 1 : 0];
            end
            else if (cmd.blend_fix && (i < MAX_FRAGS - 1))
                lane_reg[i] <= lane_reg[(i < MAX_FRAGS - 1) ? i + 1 : i];
        end
    end

    // blend: products, divide by 255 through reciprocal, correction
    logic [7:0]  col [3];
    logic [7:0]  alpha;
    logic [23:0] p1_reg [3], p2_reg [3], x_reg [3];
    logic [16:0] q0_reg [3];
    logic [15:0] v_reg [3];

    assign col[0] = lane_reg[0].red;
    assign col[1] = lane_reg[0].green;
    assign col[2] = lane_reg[0].blue;
    assign alpha  = lane_reg[0].alpha;

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [23:0] sum;
        logic [32:0] recip;
        logic [25:0] rem;
        logic [16:0] q;

        assign sum   = p1_reg[c] + p2_reg[c] + 24'd127;
        assign recip = 33'(sum) * 33'd257;
        assign rem   = 26'(x_reg[c]) - (26'(q0_reg[c]) << 8) + 26'(q0_reg[c]);
        assign q     = q0_reg[c] + ((rem >= 26'd510) ? 17'd2
                                    : (rem >= 26'd255) ? 17'd1 : 17'd0);

        always_ff @(posedge clk)
        begin
            if (cmd.comp_init)
                v_reg[c] <= {base_reg[c], base_reg[c]};
            if (cmd.blend_mul)
            begin
                p1_reg[c] <= 24'({col[c], col[c]}) * 24'(alpha);
                p2_reg[c] <= 24'(v_reg[c]) * (24'd255 - 24'(alpha));
            end
            if (cmd.blend_div)
            begin
                x_reg[c]  <= sum;
                q0_reg[c] <= recip[32:16];
            end
            if (cmd.blend_fix)
                v_reg[c] <= q[15:0];
        end
    end

    // result register
    logic       out_valid_reg;
    logic [7:0] out_col_reg [3];
    status_t    out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            for (int c = 0; c < 3; c++)
                out_col_reg[c] <= (cmd.out_status == ST_COMPOSED) ? to_byte(v_reg[c])
                                                                  : base_reg[c];
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_red   = out_col_reg[0];
    assign out_ch.out_green = out_col_reg[1];
    assign out_ch.out_blue  = out_col_reg[2];
    assign out_ch.status    = out_status_reg;

    assign sts.in_valid   = in_ch.valid;
    assign sts.op         = op_reg;
    assign sts.in_range   = in_range;
    assign sts.cnt_full   = (cnt_q >= CW'(MAX_FRAGS));
    assign sts.cnt_zero   = (cnt_q == '0);
    assign sts.clr_last   = &clr_addr_reg;
    assign sts.fetch_done = (fetch_idx_reg == n_reg);
    assign sts.blend_last = (left_reg == CW'(1));
    assign sts.out_busy   = out_valid_reg && !out_ch.ready;

endmodule

FILE: src/oit_fragment_buffer_compositor_unit.sv
// top level of the order-independent transparency fragment buffer compositor
// One item is taken at a time. An add goes through decode, count read and store
// write; a compose of n stored fragments goes through decode, count read, one store
// read per fragment into the sorting lanes, then a multiply, divide and correction
// step per fragment in the blend unit; out-of-range or empty composes skip both.
// A clear op, and reset, sweep the count memory one pixel a cycle over all
// 2^(ceil(log2 MAX_WIDTH) + ceil(log2 MAX_HEIGHT)) entries (65536 at 256 x 256),
// during which no item is accepted; configuration writes are taken at any time.
// A finished result waits in an output register while the next item is accepted.
module oit_fragment_buffer_compositor_unit
    import ofbc_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_FRAGS  = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    ofbc_in_if.sink          in_ch,
    ofbc_out_if.source       out_ch
);

    cmd_t cmd;
    sts_t sts;

    ofbc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ofbc_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_FRAGS  (MAX_FRAGS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

FILE: dv/ofbc_checker.sv
// checker for the fragment buffer compositor: per-pixel store model, compose prediction, compare
`timescale 1ns / 100ps
module ofbc_checker
    import ofbc_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_FRAGS  = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    ofbc_in_if               in_ch,
    ofbc_out_if              out_ch,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        status_t    status;
    } pixel_color_t;

    pixel_color_t     color_q[$];
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      frag_cnt [MAX_WIDTH*MAX_HEIGHT];
    frag_t            frag_mem [MAX_WIDTH*MAX_HEIGHT*MAX_FRAGS];

    function automatic int unsigned blend_step(int unsigned s, int unsigned v, int unsigned a);
        return (s * a + v * (255 - a) + 127) / 255;
    endfunction

    function automatic logic [7:0] q16_to_byte(int unsigned v);
        int unsigned b;
        b = (v * 255 + 32767) / 65535;
        return (b > 255) ? 8'hFF : b[7:0];
    endfunction

    function automatic pixel_color_t compose_pixel(int unsigned pix, logic [7:0] br,
                                                   logic [7:0] bg, logic [7:0] bb);
        int unsigned  order[MAX_FRAGS];
        int unsigned  n, i, j, cur;
        int unsigned  vr, vg, vb;
        frag_t        f;
        pixel_color_t res;
        n = frag_cnt[pix];
        if (n > MAX_FRAGS)
            n = MAX_FRAGS;
        // stable insertion, farther first
        for (i = 0; i < n; i++)
        begin
            cur = pix * MAX_FRAGS + i;
            j = i;
            while (j > 0 && frag_mem[order[j-1]].depth < frag_mem[cur].depth)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        vr = br * 257;
        vg = bg * 257;
        vb = bb * 257;
        for (i = 0; i < n; i++)
        begin
            f = frag_mem[order[i]];
            vr = blend_step(f.red * 257, vr, f.alpha);
            vg = blend_step(f.green * 257, vg, f.alpha);
            vb = blend_step(f.blue * 257, vb, f.alpha);
        end
        res.red    = q16_to_byte(vr);
        res.green  = q16_to_byte(vg);
        res.blue   = q16_to_byte(vb);
        res.status = ST_COMPOSED;
        return res;
    endfunction

    task automatic take_item();
        int           x, y;
        int unsigned  w, h, pix, n;
        logic         in_range;
        pixel_color_t res;
        x = in_ch.pos_x;
        y = in_ch.pos_y;
        w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        in_range = (x >= 0) && (y >= 0) && (x < w) && (y < h);
        pix = in_range ? y * MAX_WIDTH + x : 0;
        case (in_ch.op)
            OP_CLEAR:
                for (int i = 0; i < MAX_WIDTH*MAX_HEIGHT; i++)
                    frag_cnt[i] = 0;
            OP_ADD:
                if (in_range && frag_cnt[pix] < MAX_FRAGS)
                begin
                    n = frag_cnt[pix];
                    frag_mem[pix*MAX_FRAGS+n] = {in_ch.frag_depth, in_ch.frag_red,
                        in_ch.frag_green, in_ch.frag_blue, in_ch.frag_alpha};
                    frag_cnt[pix] = n + 1;
                end
            OP_COMPOSE:
            begin
                if (!in_range || frag_cnt[pix] == 0)
                begin
                    res.red    = in_ch.base_red;
                    res.green  = in_ch.base_green;
                    res.blue   = in_ch.base_blue;
                    res.status = in_range ? ST_EMPTY : ST_OUT_OF_RANGE;
                end
                else
                    res = compose_pixel(pix, in_ch.base_red, in_ch.base_green,
                                        in_ch.base_blue);
                color_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        pixel_color_t exp_c;
        pixel_color_t act_c;
        act_c = {out_ch.out_red, out_ch.out_green, out_ch.out_blue, status_t'(out_ch.status)};
        if (color_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, act_c);
            fail_count++;
        end
        else
        begin
            exp_c = color_q.pop_front();
            if (act_c.red !== exp_c.red)
            begin
                $display("%0t: red expected %h actual %h", $time, exp_c.red, act_c.red);
                fail_count++;
            end
            if (act_c.green !== exp_c.green)
            begin
                $display("%0t: green expected %h actual %h", $time, exp_c.green, act_c.green);
                fail_count++;
            end
            if (act_c.blue !== exp_c.blue)
            begin
                $display("%0t: blue expected %h actual %h", $time, exp_c.blue, act_c.blue);
                fail_count++;
            end
            if (act_c.status !== exp_c.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, exp_c.status,
                         act_c.status);
                fail_count++;
            end
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    // sample mid cycle, what is seen here is taken at the next rising edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            width_reg  = 256;
            height_reg = 256;
            for (int i = 0; i < MAX_WIDTH*MAX_HEIGHT; i++)
                frag_cnt[i] = 0;
            color_q.delete();
        end
        else
        begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                take_item();
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                check_result();
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
        end
        pending = color_q.size();
    end

endmodule

FILE: dv/oit_fragment_buffer_compositor_unit_tb.sv
// testbench top: stimulus, receiver stalls, watchdog and verdict for the compositor
`timescale 1ns / 100ps
module oit_fragment_buffer_compositor_unit_tb;
    import ofbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES    = 400;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    logic             no_idle;
    logic             hold_req;
    int               idle_cycles;
    int               cur_w;
    int               cur_h;

    ofbc_in_if  in_if();
    ofbc_out_if out_if();

    oit_fragment_buffer_compositor_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_if),
        .out_ch   (out_if)
    );

    ofbc_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic send_item(logic [1:0] op, int x, int y, logic [23:0] depth,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                             logic [7:0] br, logic [7:0] bg, logic [7:0] bb);
        if (!no_idle)
            while ($urandom_range(99) < 32)
            begin
                in_if.valid <= 1'b0;
                @(posedge clk);
            end
        in_if.valid      <= 1'b1;
        in_if.op         <= op;
        in_if.pos_x      <= 11'(x);
        in_if.pos_y      <= 11'(y);
        in_if.frag_depth <= depth;
        in_if.frag_red   <= r;
        in_if.frag_green <= g;
        in_if.frag_blue  <= b;
        in_if.frag_alpha <= a;
        in_if.base_red   <= br;
        in_if.base_green <= bg;
        in_if.base_blue  <= bb;
        do
            @(negedge clk);
        while (in_if.ready !== 1'b1);
        @(posedge clk);
    endtask

    task automatic write_size(int w, int h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= CFG_W'(h);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    // wait out every result, then let a trailing add settle
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic int pick_coord(int lim);
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return $urandom_range(7);
        else if (sel < 80)
            return $urandom_range(1023);
        else if (sel < 90)
            return -$urandom_range(1024, 1);
        else
            return (lim > 0) ? lim - $urandom_range(1) : 0;
    endfunction

    function automatic logic [23:0] pick_depth();
        case ($urandom_range(9))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'd100;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_random();
        int          sel;
        logic [1:0]  op;
        sel = $urandom_range(99);
        if (sel < 55)
            op = OP_ADD;
        else if (sel < 97)
            op = OP_COMPOSE;
        else
            op = OP_UNUSED;
        send_item(op, pick_coord(cur_w), pick_coord(cur_h), pick_depth(),
                  8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // receiver: random stalls, always ready in the no-idle pass, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            out_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_req = 1'b0;
        end
        else if (no_idle)
            out_if.ready <= 1'b1;
        else
            out_if.ready <= ($urandom_range(99) >= 32);
    end

    always @(negedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int pw[6];
        int ph[6];
        pw = '{4, 1, 511, 0, 256, 3};
        ph = '{4, 1, 2, 7, 256, 300};
        idle_cycles = 0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_WIDTH;
        cfg_data    = '0;
        out_if.ready = 1'b0;
        in_if.valid = 1'b0;
        in_if.op = OP_CLEAR;
        in_if.pos_x = '0;
        in_if.pos_y = '0;
        in_if.frag_depth = '0;
        in_if.frag_red = '0;
        in_if.frag_green = '0;
        in_if.frag_blue = '0;
        in_if.frag_alpha = '0;
        in_if.base_red = '0;
        in_if.base_green = '0;
        in_if.base_blue = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_size(256, 256);

        // directed: field extremes, full pixel, ties, empty, out of range, op 3, clear
        send_item(OP_ADD, 0, 0, 24'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0);
        send_item(OP_ADD, 0, 0, 24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0);
        send_item(OP_ADD, 255, 255, 24'h800000, 8'hAA, 8'h55, 8'h0F, 8'h80, 0, 0, 0);
        send_item(OP_ADD, -1, 0, 24'd5, 8'h11, 8'h22, 8'h33, 8'h44, 0, 0, 0);
        send_item(OP_ADD, 256, 0, 24'd5, 8'h11, 8'h22, 8'h33, 8'h44, 0, 0, 0);
        send_item(OP_ADD, 0, -1024, 24'd5, 8'h11, 8'h22, 8'h33, 8'h44, 0, 0, 0);
        send_item(OP_ADD, 1023, 1023, 24'd5, 8'h11, 8'h22, 8'h33, 8'h44, 0, 0, 0);
        // nine adds to one pixel: three equal depths, ninth one dropped
        for (int i = 0; i < 9; i++)
            send_item(OP_ADD, 1, 0, (i % 3 == 0) ? 24'd7 : 24'(1000 * i),
                      8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 0, 0, 0);
        send_item(OP_COMPOSE, 0, 0, 0, 0, 0, 0, 0, 8'd0, 8'd0, 8'd0);
        send_item(OP_COMPOSE, 1, 0, 0, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF);
        send_item(OP_COMPOSE, 2, 0, 0, 0, 0, 0, 0, 8'h12, 8'h34, 8'h56);
        send_item(OP_COMPOSE, -1, 5, 0, 0, 0, 0, 0, 8'h9A, 8'hBC, 8'hDE);
        send_item(OP_COMPOSE, 255, 255, 0, 0, 0, 0, 0, 8'h40, 8'h80, 8'hC0);
        send_item(OP_UNUSED, 0, 0, 24'h123456, 8'h1, 8'h2, 8'h3, 8'h4, 8'h5, 8'h6, 8'h7);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_COMPOSE, 0, 0, 0, 0, 0, 0, 0, 8'h01, 8'h02, 8'h03);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_size(pw[p], ph[p]);
            if (p == 0 || p == 3)
                send_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
            no_idle = (p == 2);
            for (int k = 0; k < 200; k++)
            begin
                if (p == 1 && k == 20)
                    hold_req = 1'b1;
                send_random();
            end
            drain();
        end
        no_idle = 1'b0;
        drain();

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: oit_fragment_buffer_compositor_unit.f
src/ofbc_pkg.sv
src/ofbc_ifs.sv
src/ofbc_ctrl.sv
src/ofbc_dp.sv
src/oit_fragment_buffer_compositor_unit.sv
dv/ofbc_checker.sv
dv/oit_fragment_buffer_compositor_unit_tb.sv
